FILE: src/msos_pkg.sv
// ----------------------------------------------------------------------------
// msos_pkg
// Shared constants and types for the seam owner select block: table sizing,
// fixed point widths and the packed image box record.
// ----------------------------------------------------------------------------
`default_nettype none

package msos_pkg;

   // table and field sizing
   localparam int MAX_IMAGES = 16;
   localparam int COORD_BITS = 24;
   localparam int IDX_W      = $clog2(MAX_IMAGES);
   localparam int CNT_W      = $clog2(MAX_IMAGES + 1);
   localparam int IMG_IDX_W  = 4;
   localparam int NUM_IMG_W  = 5;
   localparam int PIX_W      = 16;
   localparam int W_W        = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int WT_W       = 9;

   // pixel center in Q.4, unsigned
   localparam int CTR_W  = PIX_W + 4;
   // signed compare width of center against box edges
   localparam int CW     = ((COORD_BITS > CTR_W) ? COORD_BITS : CTR_W) + 1;
   // doubled center
   localparam int DC_W   = COORD_BITS + 1;
   // magnitude of doubled center difference
   localparam int MAG_W  = (((CTR_W + 1) > COORD_BITS) ? (CTR_W + 1) : COORD_BITS) + 1;
   localparam int AD_W   = MAG_W + 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int DD_W   = SQ_W + 1;
   // square root widths
   localparam int SQI_W  = DD_W + (DD_W % 2);
   localparam int RT_W   = SQI_W / 2;
   // seam distance widths
   localparam int E_W    = CW - 1;
   localparam int DIST_W = (RT_W > E_W) ? RT_W : E_W;
   // feather weight divide
   localparam int QW     = 7;
   localparam int NUM_W  = W_W + QW;

   localparam logic [WT_W-1:0] WT_HALF = WT_W'(128);
   localparam logic [WT_W-1:0] WT_FULL = WT_W'(256);

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SELECT_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEATHER_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEATHER_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_IMAGES     = 2'd3;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_min;
      logic signed [COORD_BITS-1:0] x_max;
      logic signed [COORD_BITS-1:0] y_min;
      logic signed [COORD_BITS-1:0] y_max;
      logic signed [DC_W-1:0]       dcx;
      logic signed [DC_W-1:0]       dcy;
   } box_type;

endpackage

`default_nettype wire

FILE: src/msos_ram.sv
// ----------------------------------------------------------------------------
// msos_ram
// Simple dual port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module msos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: src/msos_isqrt.sv
// ----------------------------------------------------------------------------
// msos_isqrt
// Digit by digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msos_isqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [msos_pkg::DD_W-1:0]   radicand,
   output logic                             done,
   output logic      [msos_pkg::RT_W-1:0]   root
);
   import msos_pkg::*;

   localparam int STEP_W = $clog2(RT_W + 1);

   logic [SQI_W-1:0]  rad_ff;
   logic [RT_W+1:0]   rem_ff;
   logic [RT_W-1:0]   root_ff;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff;
   logic              done_ff;

   logic [RT_W+1:0]   rem_shift;
   logic [RT_W+1:0]   trial;
   logic              take;

   // one trial subtract per step
   always_comb begin
      rem_shift = {rem_ff[RT_W-1:0], rad_ff[SQI_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      take      = (rem_shift >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= STEP_W'(RT_W);
            rad_ff  <= SQI_W'(radicand);
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (run_ff) begin
            rad_ff  <= {rad_ff[SQI_W-3:0], 2'b00};
            rem_ff  <= take ? (rem_shift - trial) : rem_shift;
            root_ff <= {root_ff[RT_W-2:0], take};
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

FILE: src/msos_div.sv
// ----------------------------------------------------------------------------
// msos_div
// Restoring divider for the feather weight; quotient known to fit QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module msos_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [msos_pkg::NUM_W-1:0]  numer,
   input  wire logic [msos_pkg::W_W-1:0]    denom,
   output logic                             done,
   output logic      [msos_pkg::QW-1:0]     quot
);
   import msos_pkg::*;

   localparam int K_W = $clog2(QW);

   logic [NUM_W-1:0] rem_ff;
   logic [W_W-1:0]   den_ff;
   logic [QW-1:0]    quot_ff;
   logic [K_W-1:0]   k_ff;
   logic             run_ff;
   logic             done_ff;

   logic [NUM_W-1:0] trial;
   logic             take;

   // shifted divisor for the current quotient bit
   always_comb begin
      trial = NUM_W'(den_ff) << k_ff;
      take  = (rem_ff >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            rem_ff  <= numer;
            den_ff  <= denom;
            quot_ff <= '0;
            k_ff    <= K_W'(QW - 1);
         end else if (run_ff) begin
            if (take) begin
               rem_ff <= rem_ff - trial;
            end
            quot_ff[k_ff] <= take;
            k_ff <= k_ff - K_W'(1);
            if (k_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

FILE: src/mosaic_seam_owner_select_core.sv
// ----------------------------------------------------------------------------
// mosaic_seam_owner_select_core
// Picks the owning image and a blend partner for one output mosaic pixel.
// ----------------------------------------------------------------------------
`default_nettype none

// A load transfer writes one image box into the table and returns nothing.
// A query transfer scans table entries 0 to num_images-1 (capped at 15)
// through a pipelined read of the box table (one entry per cycle), then,
// when feathering applies, runs two bit-serial square roots in parallel
// (Voronoi mode only) and, when the seam distance is under the blend limit,
// a divide for the weight. One item is worked on at a time; the next item
// may be taken while a result waits.
module mosaic_seam_owner_select_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration writes
   input  wire logic                                 csr_wr_en,
   input  wire logic [msos_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [msos_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_command,
   input  wire logic [msos_pkg::IMG_IDX_W-1:0]       req_image_index,
   input  wire logic signed [msos_pkg::COORD_BITS-1:0] req_box_x_min,
   input  wire logic signed [msos_pkg::COORD_BITS-1:0] req_box_x_max,
   input  wire logic signed [msos_pkg::COORD_BITS-1:0] req_box_y_min,
   input  wire logic signed [msos_pkg::COORD_BITS-1:0] req_box_y_max,
   input  wire logic [msos_pkg::PIX_W-1:0]           req_pixel_col,
   input  wire logic [msos_pkg::PIX_W-1:0]           req_pixel_row,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_owner_found,
   output logic      [msos_pkg::IMG_IDX_W-1:0]       rsp_owner,
   output logic                                      rsp_second_found,
   output logic      [msos_pkg::IMG_IDX_W-1:0]       rsp_second,
   output logic                                      rsp_blend,
   output logic      [msos_pkg::WT_W-1:0]            rsp_owner_weight
);
   import msos_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_FEATH = 3'd2;
   localparam logic [2:0] S_SQRT  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   // configuration
   logic                 select_mode_ff;
   logic                 feather_enable_ff;
   logic [W_W-1:0]       feather_width_ff;
   logic [NUM_IMG_W-1:0] num_images_ff;

   logic [2:0] state_ff, state_in;

   // query context
   logic [CTR_W-1:0] cx_ff, cy_ff;
   logic [CNT_W-1:0] n_ff, rd_cnt_ff;

   // scan pipeline
   logic             p0_v_ff;
   logic [IDX_W-1:0] p0_idx_ff;
   logic             s1_v_ff, s1_cover_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [MAG_W-1:0] s1_ax_ff, s1_ay_ff;
   box_type          s1_box_ff;
   logic             s2_v_ff, s2_cover_ff;
   logic [IDX_W-1:0] s2_idx_ff;
   logic [SQ_W-1:0]  s2_sx_ff, s2_sy_ff;
   box_type          s2_box_ff;

   // selection
   logic             has1_ff, has2_ff;
   logic [IDX_W-1:0] own_ff, sec_ff;
   logic [DD_W-1:0]  d1_ff, d2_ff;
   box_type          own_box_ff;

   // feather
   logic [DIST_W-1:0] dist_ff;
   logic              blend_ff;
   logic [WT_W-1:0]   weight_ff;

   // response registers
   logic                 rsp_valid_ff;
   logic                 rsp_owner_found_ff, rsp_second_found_ff, rsp_blend_ff;
   logic [IMG_IDX_W-1:0] rsp_owner_ff, rsp_second_ff;
   logic [WT_W-1:0]      rsp_weight_ff;

   // table
   logic             ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   box_type          ram_wr_data, ram_rd_data;

   logic req_xfer, load_xfer, query_xfer;
   logic [CNT_W-1:0] n_eff;
   logic scan_done;
   logic [W_W-1:0] w_eff;

   // stage one
   logic signed [CW-1:0]   cx_s, cy_s;
   logic signed [AD_W-1:0] tx_s, ty_s, dx_s, dy_s;
   logic                   cover_c;
   logic [MAG_W-1:0]       ax_c, ay_c;

   // stage three
   logic [DD_W-1:0] dd_c;

   // overlay edge distance
   logic signed [CW-1:0] ox_s, oy_s;
   logic [E_W-1:0]       e_l, e_r, e_t, e_b, e_min;

   // feather limit and divide operands
   logic [DIST_W-1:0] lim_c;
   logic [NUM_W-1:0]  numer_c;

   logic            sqrt_start, sqrt_done, sqrt_done2;
   logic [RT_W-1:0] root1, root2;
   logic            div_start, div_done;
   logic [QW-1:0]   div_quot;

   // handshake
   assign req_ready  = (state_ff == S_IDLE);
   assign req_xfer   = req_valid && req_ready;
   assign load_xfer  = req_xfer && (req_command == CMD_LOAD);
   assign query_xfer = req_xfer && (req_command == CMD_QUERY);

   assign n_eff = (32'(num_images_ff) > MAX_IMAGES) ? CNT_W'(MAX_IMAGES)
                                                     : CNT_W'(num_images_ff);
   assign w_eff = (feather_width_ff == '0) ? W_W'(1) : feather_width_ff;

   // table write on load, read during scan
   always_comb begin
      ram_wr_en         = load_xfer && (32'(req_image_index) < MAX_IMAGES);
      ram_wr_addr       = IDX_W'(req_image_index);
      ram_wr_data.x_min = req_box_x_min;
      ram_wr_data.x_max = req_box_x_max;
      ram_wr_data.y_min = req_box_y_min;
      ram_wr_data.y_max = req_box_y_max;
      ram_wr_data.dcx   = DC_W'(req_box_x_min) + DC_W'(req_box_x_max);
      ram_wr_data.dcy   = DC_W'(req_box_y_min) + DC_W'(req_box_y_max);
      ram_rd_en         = (state_ff == S_SCAN) && (rd_cnt_ff < n_ff);
      ram_rd_addr       = IDX_W'(rd_cnt_ff);
   end

   msos_ram #(
      .WIDTH ($bits(box_type)),
      .DEPTH (MAX_IMAGES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // coverage test and center offsets for the entry just read
   always_comb begin
      cx_s    = CW'(cx_ff);
      cy_s    = CW'(cy_ff);
      cover_c = (cx_s >= CW'(ram_rd_data.x_min)) && (cx_s <= CW'(ram_rd_data.x_max)) &&
                (cy_s >= CW'(ram_rd_data.y_min)) && (cy_s <= CW'(ram_rd_data.y_max));
      tx_s    = AD_W'({cx_ff, 1'b0});
      ty_s    = AD_W'({cy_ff, 1'b0});
      dx_s    = tx_s - AD_W'(ram_rd_data.dcx);
      dy_s    = ty_s - AD_W'(ram_rd_data.dcy);
      ax_c    = MAG_W'((dx_s < 0) ? -dx_s : dx_s);
      ay_c    = MAG_W'((dy_s < 0) ? -dy_s : dy_s);
   end

   assign dd_c = DD_W'(s2_sx_ff) + DD_W'(s2_sy_ff);

   assign scan_done = (rd_cnt_ff >= n_ff) && !p0_v_ff && !s1_v_ff && !s2_v_ff;

   // nearest edge of the overlay owner
   always_comb begin
      ox_s  = CW'(cx_ff);
      oy_s  = CW'(cy_ff);
      e_l   = E_W'(ox_s - CW'(own_box_ff.x_min));
      e_r   = E_W'(CW'(own_box_ff.x_max) - ox_s);
      e_b   = E_W'(CW'(own_box_ff.y_max) - oy_s);
      e_t   = E_W'(oy_s - CW'(own_box_ff.y_min));
      e_min = e_l;
      if (e_r < e_min) e_min = e_r;
      if (e_b < e_min) e_min = e_b;
      if (e_t < e_min) e_min = e_t;
   end

   // blend limit and weight numerator
   always_comb begin
      if (select_mode_ff) begin
         lim_c   = DIST_W'({w_eff, 6'b0});
         numer_c = {dist_ff[NUM_W-2:0], 1'b0};
      end else begin
         lim_c   = DIST_W'({w_eff, 4'b0});
         numer_c = {dist_ff[NUM_W-4:0], 3'b0};
      end
   end

   assign sqrt_start = (state_ff == S_FEATH) && feather_enable_ff && has1_ff &&
                       has2_ff && select_mode_ff;
   assign div_start  = (state_ff == S_CHECK) && (dist_ff < lim_c);

   msos_isqrt u_sqrt_own (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (d1_ff),
      .done     (sqrt_done),
      .root     (root1)
   );

   msos_isqrt u_sqrt_sec (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (d2_ff),
      .done     (sqrt_done2),
      .root     (root2)
   );

   msos_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (numer_c),
      .denom (w_eff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (query_xfer) state_in = S_SCAN;
         S_SCAN:  if (scan_done) state_in = S_FEATH;
         S_FEATH: begin
            if (!(feather_enable_ff && has1_ff && has2_ff)) state_in = S_DONE;
            else if (select_mode_ff) state_in = S_SQRT;
            else state_in = S_CHECK;
         end
         S_SQRT:  if (sqrt_done && sqrt_done2) state_in = S_CHECK;
         S_CHECK: state_in = div_start ? S_DIV : S_DONE;
         S_DIV:   if (div_done) state_in = S_DONE;
         S_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         select_mode_ff    <= 1'b1;
         feather_enable_ff <= 1'b0;
         feather_width_ff  <= W_W'(1);
         num_images_ff     <= NUM_IMG_W'(1);
         p0_v_ff           <= 1'b0;
         s1_v_ff           <= 1'b0;
         s2_v_ff           <= 1'b0;
         has1_ff           <= 1'b0;
         has2_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;

         // configuration writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SELECT_MODE:    select_mode_ff    <= csr_wdata[0];
               CSR_FEATHER_ENABLE: feather_enable_ff <= csr_wdata[0];
               CSR_FEATHER_WIDTH:  feather_width_ff  <= csr_wdata[W_W-1:0];
               CSR_NUM_IMAGES:     num_images_ff     <= csr_wdata[NUM_IMG_W-1:0];
               default: ;
            endcase
         end

         // scan pipeline valids
         p0_v_ff <= ram_rd_en;
         s1_v_ff <= p0_v_ff;
         s2_v_ff <= s1_v_ff;

         // ownership selection
         if (query_xfer) begin
            has1_ff <= 1'b0;
            has2_ff <= 1'b0;
         end else if (s2_v_ff && s2_cover_ff) begin
            if (select_mode_ff) begin
               if (!has1_ff || dd_c < d1_ff) begin
                  if (has1_ff) has2_ff <= 1'b1;
                  has1_ff <= 1'b1;
               end else if (!has2_ff || dd_c < d2_ff) begin
                  has2_ff <= 1'b1;
               end
            end else begin
               if (!has1_ff) has1_ff <= 1'b1;
               else has2_ff <= 1'b1;
            end
         end

         // response register
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      // query start
      if (query_xfer) begin
         cx_ff     <= {req_pixel_col, 4'h8};
         cy_ff     <= {req_pixel_row, 4'h8};
         n_ff      <= n_eff;
         rd_cnt_ff <= '0;
         own_ff    <= '0;
         sec_ff    <= '0;
      end else if (ram_rd_en) begin
         rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
      end

      // read stage
      p0_idx_ff <= ram_rd_addr;

      // compare stage
      s1_idx_ff   <= p0_idx_ff;
      s1_cover_ff <= cover_c;
      s1_ax_ff    <= ax_c;
      s1_ay_ff    <= ay_c;
      s1_box_ff   <= ram_rd_data;

      // square stage
      s2_idx_ff   <= s1_idx_ff;
      s2_cover_ff <= s1_cover_ff;
      s2_sx_ff    <= s1_ax_ff * s1_ax_ff;
      s2_sy_ff    <= s1_ay_ff * s1_ay_ff;
      s2_box_ff   <= s1_box_ff;

      // selection payload
      if (!query_xfer && s2_v_ff && s2_cover_ff) begin
         if (select_mode_ff) begin
            if (!has1_ff || dd_c < d1_ff) begin
               if (has1_ff) begin
                  sec_ff <= own_ff;
                  d2_ff  <= d1_ff;
               end
               own_ff     <= s2_idx_ff;
               d1_ff      <= dd_c;
               own_box_ff <= s2_box_ff;
            end else if (!has2_ff || dd_c < d2_ff) begin
               sec_ff <= s2_idx_ff;
               d2_ff  <= dd_c;
            end
         end else begin
            if (!has1_ff) begin
               own_ff     <= s2_idx_ff;
               own_box_ff <= s2_box_ff;
            end else if (!has2_ff) begin
               sec_ff <= s2_idx_ff;
            end
         end
      end

      // feather
      case (state_ff)
         S_FEATH: begin
            blend_ff  <= 1'b0;
            weight_ff <= WT_FULL;
            dist_ff   <= DIST_W'(e_min);
         end
         S_SQRT: begin
            if (sqrt_done) dist_ff <= DIST_W'(root2 - root1);
         end
         S_DIV: begin
            if (div_done) begin
               blend_ff  <= 1'b1;
               weight_ff <= WT_HALF + WT_W'(div_quot);
            end
         end
         default: ;
      endcase

      // result capture
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_owner_found_ff  <= has1_ff;
         rsp_owner_ff        <= has1_ff ? IMG_IDX_W'(own_ff) : '0;
         rsp_second_found_ff <= has2_ff;
         rsp_second_ff       <= has2_ff ? IMG_IDX_W'(sec_ff) : '0;
         rsp_blend_ff        <= blend_ff;
         rsp_weight_ff       <= weight_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_owner_found  = rsp_owner_found_ff;
   assign rsp_owner        = rsp_owner_ff;
   assign rsp_second_found = rsp_second_found_ff;
   assign rsp_second       = rsp_second_ff;
   assign rsp_blend        = rsp_blend_ff;
   assign rsp_owner_weight = rsp_weight_ff;

`ifndef ASSERT_OFF
   // no second image or blend without an owner
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_owner_found |-> !rsp_second_found && !rsp_blend &&
                                        rsp_owner_weight == WT_FULL)
      else $error("response without owner carries second or blend");

   // blended weight stays in the upper half
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blend |-> rsp_owner_weight >= WT_HALF &&
                                 rsp_owner_weight < WT_FULL)
      else $error("blend weight out of range");

   // scan pipeline drained whenever a new transfer may be taken
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !p0_v_ff && !s1_v_ff && !s2_v_ff)
      else $error("scan pipeline busy while idle");
`endif

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the seam owner select core: loads image boxes,
// sends pixel queries under several register settings and compares every
// result against a predictor of ownership, second image and feather weight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import msos_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 64;

   typedef struct packed {
      logic                         command;
      logic [IMG_IDX_W-1:0]         image_index;
      logic signed [COORD_BITS-1:0] x_min;
      logic signed [COORD_BITS-1:0] x_max;
      logic signed [COORD_BITS-1:0] y_min;
      logic signed [COORD_BITS-1:0] y_max;
      logic [PIX_W-1:0]             col;
      logic [PIX_W-1:0]             row;
   } pixel_request_type;

   typedef struct packed {
      logic                 owner_found;
      logic [IMG_IDX_W-1:0] owner;
      logic                 second_found;
      logic [IMG_IDX_W-1:0] second;
      logic                 blend;
      logic [WT_W-1:0]      owner_weight;
   } ownership_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   pixel_request_type req = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ownership_type rsp;

   pixel_request_type pending_requests[$];
   ownership_type     expected_owners[$];

   // predictor copy of registers and box table
   logic       pm_select_mode = 1'b1;
   logic       pm_feather_en  = 1'b0;
   logic [9:0] pm_width       = 10'd1;
   logic [4:0] pm_num_images  = 5'd1;
   longint     tbl_x_lo[MAX_IMAGES], tbl_x_hi[MAX_IMAGES];
   longint     tbl_y_lo[MAX_IMAGES], tbl_y_hi[MAX_IMAGES];
   longint     tbl_dcx[MAX_IMAGES], tbl_dcy[MAX_IMAGES];

   int  error_count = 0;
   int  load_count = 0, query_count = 0, blend_count = 0, result_count = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  long_stall_done = 1'b0;
   bit  quiet_phase = 1'b0;

   always #2 clock = ~clock;

   mosaic_seam_owner_select_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req.command),
      .req_image_index  (req.image_index),
      .req_box_x_min    (req.x_min),
      .req_box_x_max    (req.x_max),
      .req_box_y_min    (req.y_min),
      .req_box_y_max    (req.y_max),
      .req_pixel_col    (req.col),
      .req_pixel_row    (req.row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_owner_found  (rsp.owner_found),
      .rsp_owner        (rsp.owner),
      .rsp_second_found (rsp.second_found),
      .rsp_second       (rsp.second),
      .rsp_blend        (rsp.blend),
      .rsp_owner_weight (rsp.owner_weight)
   );

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned abs_gap(longint a, longint b);
      return (a >= b) ? longint'(a - b) : longint'(b - a);
   endfunction

   // apply one transfer to the predictor; returns 1 when a result is due
   function automatic bit predict_ownership(pixel_request_type r, output ownership_type res);
      longint cx, cy, ex;
      longint unsigned dd, d_own, d_sec, w, gap, e;
      int n, own, sec;
      bit has_own, has_sec;
      res = '0;
      res.owner_weight = WT_FULL;
      if (r.command == CMD_LOAD) begin
         tbl_x_lo[r.image_index] = r.x_min;
         tbl_x_hi[r.image_index] = r.x_max;
         tbl_y_lo[r.image_index] = r.y_min;
         tbl_y_hi[r.image_index] = r.y_max;
         tbl_dcx[r.image_index]  = longint'(r.x_min) + longint'(r.x_max);
         tbl_dcy[r.image_index]  = longint'(r.y_min) + longint'(r.y_max);
         return 1'b0;
      end
      cx = longint'(r.col) * 16 + 8;
      cy = longint'(r.row) * 16 + 8;
      n = (pm_num_images > MAX_IMAGES) ? MAX_IMAGES : int'(pm_num_images);
      has_own = 0; has_sec = 0; own = 0; sec = 0; d_own = 0; d_sec = 0;
      for (int i = 0; i < n; i++) begin
         if (!(cx >= tbl_x_lo[i] && cx <= tbl_x_hi[i] &&
               cy >= tbl_y_lo[i] && cy <= tbl_y_hi[i]))
            continue;
         if (pm_select_mode) begin
            // squared distance between doubled centers
            dd = abs_gap(2 * cx, tbl_dcx[i]) * abs_gap(2 * cx, tbl_dcx[i])
               + abs_gap(2 * cy, tbl_dcy[i]) * abs_gap(2 * cy, tbl_dcy[i]);
            if (!has_own || dd < d_own) begin
               if (has_own) begin
                  has_sec = 1; sec = own; d_sec = d_own;
               end
               has_own = 1; own = i; d_own = dd;
            end else if (!has_sec || dd < d_sec) begin
               has_sec = 1; sec = i; d_sec = dd;
            end
         end else begin
            if (!has_own) begin
               has_own = 1; own = i;
            end else begin
               has_sec = 1; sec = i;
               break;
            end
         end
      end
      // feather weight near the seam
      if (pm_feather_en && has_own && has_sec) begin
         w = (pm_width == 0) ? 1 : pm_width;
         if (pm_select_mode) begin
            gap = floor_sqrt(d_sec) - floor_sqrt(d_own);
            if (gap < 64 * w) begin
               res.blend = 1'b1;
               res.owner_weight = WT_W'(128 + (2 * gap) / w);
            end
         end else begin
            e = cx - tbl_x_lo[own];
            ex = tbl_x_hi[own] - cx;   if (longint'(ex) < longint'(e)) e = ex;
            ex = tbl_y_hi[own] - cy;   if (longint'(ex) < longint'(e)) e = ex;
            ex = cy - tbl_y_lo[own];   if (longint'(ex) < longint'(e)) e = ex;
            if (e < 16 * w) begin
               res.blend = 1'b1;
               res.owner_weight = WT_W'(128 + (8 * e) / w);
            end
         end
      end
      res.owner_found  = has_own;
      res.owner        = has_own ? IMG_IDX_W'(own) : '0;
      res.second_found = has_sec;
      res.second       = has_sec ? IMG_IDX_W'(sec) : '0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("tb: mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
      error_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      ownership_type res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (predict_ownership(req, res)) begin
               expected_owners.push_back(res);
               query_count++;
               if (res.blend) blend_count++;
            end else begin
               load_count++;
            end
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 &&
                (quiet_phase || $urandom_range(99) >= 6)) begin
               req_valid <= 1'b1;
               req <= pending_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      ownership_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_owners.size() == 0) begin
               report_mismatch("unexpected transfer", 1, 0);
            end else begin
               want = expected_owners.pop_front();
               if (rsp.owner_found !== want.owner_found)
                  report_mismatch("owner_found", rsp.owner_found, want.owner_found);
               if (rsp.owner !== want.owner)
                  report_mismatch("owner", rsp.owner, want.owner);
               if (rsp.second_found !== want.second_found)
                  report_mismatch("second_found", rsp.second_found, want.second_found);
               if (rsp.second !== want.second)
                  report_mismatch("second", rsp.second, want.second);
               if (rsp.blend !== want.blend)
                  report_mismatch("blend", rsp.blend, want.blend);
               if (rsp.owner_weight !== want.owner_weight)
                  report_mismatch("owner_weight", rsp.owner_weight, want.owner_weight);
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (result_count == 150 && !long_stall_done) begin
            // one long hold-off so the input side backs up
            long_stall_done <= 1'b1;
            stall_left <= 300;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_phase || ($urandom_range(99) >= 6);
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: timeout with %0d results outstanding", expected_owners.size());
            $display("tb: errors");
            $finish;
         end
      end
   end

   task automatic write_settings(bit mode, bit fe, int width, int n);
      @(posedge clock);
      csr_wr_en <= 1'b1; csr_index <= CSR_SELECT_MODE;    csr_wdata <= CSR_DATA_W'(mode);
      pm_select_mode = mode;
      @(posedge clock);
      csr_index <= CSR_FEATHER_ENABLE; csr_wdata <= CSR_DATA_W'(fe);
      pm_feather_en = fe;
      @(posedge clock);
      csr_index <= CSR_FEATHER_WIDTH;  csr_wdata <= CSR_DATA_W'(width);
      pm_width = 10'(width);
      @(posedge clock);
      csr_index <= CSR_NUM_IMAGES;     csr_wdata <= CSR_DATA_W'(n);
      pm_num_images = 5'(n);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // sender pause: wait until all requests and results have drained
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_owners.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic pixel_request_type make_load(int idx, int x0, int x1, int y0, int y1);
      pixel_request_type r;
      r = '0;
      r.command = CMD_LOAD;
      r.image_index = IMG_IDX_W'(idx);
      r.x_min = COORD_BITS'(x0); r.x_max = COORD_BITS'(x1);
      r.y_min = COORD_BITS'(y0); r.y_max = COORD_BITS'(y1);
      r.col = PIX_W'($urandom); r.row = PIX_W'($urandom);
      return r;
   endfunction

   function automatic pixel_request_type make_query(int col, int row);
      pixel_request_type r;
      r = '0;
      r.command = CMD_QUERY;
      r.image_index = IMG_IDX_W'($urandom);
      r.x_min = COORD_BITS'($urandom); r.x_max = COORD_BITS'($urandom);
      r.y_min = COORD_BITS'($urandom); r.y_max = COORD_BITS'($urandom);
      r.col = PIX_W'(col); r.row = PIX_W'(row);
      return r;
   endfunction

   // random loads and queries, mostly boxes over a small pixel area so that they overlap
   task automatic queue_random(int count);
      int x0, y0;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 25) begin
            if ($urandom_range(99) < 15) begin
               pending_requests.push_back(make_load($urandom_range(15), $urandom, $urandom,
                                                    $urandom, $urandom));
            end else begin
               x0 = int'($urandom_range(1024)) - 200;
               y0 = int'($urandom_range(1024)) - 200;
               pending_requests.push_back(make_load($urandom_range(15),
                  x0, x0 + int'($urandom_range(900)) - 20,
                  y0, y0 + int'($urandom_range(900)) - 20));
            end
         end else if ($urandom_range(99) < 10) begin
            pending_requests.push_back(make_query($urandom_range(65535), $urandom_range(65535)));
         end else begin
            pending_requests.push_back(make_query($urandom_range(70), $urandom_range(70)));
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: fill the whole table, then corner and interior queries
      write_settings(1'b1, 1'b1, 4, 16);
      pending_requests.push_back(make_load(0, -8388608, 8388607, -8388608, 8388607));
      pending_requests.push_back(make_load(1, 0, 16, 0, 16));
      pending_requests.push_back(make_load(2, 40, 8, 40, 8));           // inverted box
      pending_requests.push_back(make_load(3, 8, 1048568, 8, 1048568));
      pending_requests.push_back(make_load(4, 8388607, 8388607, 8388607, 8388607));
      for (int i = 5; i < MAX_IMAGES; i++)
         pending_requests.push_back(make_load(i, 16 * i, 16 * i + 400, 0, 600));
      pending_requests.push_back(make_query(0, 0));
      pending_requests.push_back(make_query(65535, 65535));
      pending_requests.push_back(make_query(0, 65535));
      pending_requests.push_back(make_query(10, 3));
      pending_requests.push_back(make_query(30, 20));
      pending_requests.push_back(make_query(70, 36));
      wait_drained();

      // overlay mode with feathering on, then nothing scanned and feathering off
      write_settings(1'b0, 1'b1, 1, 16);
      pending_requests.push_back(make_query(0, 0));
      pending_requests.push_back(make_query(12, 12));
      pending_requests.push_back(make_query(40, 10));
      wait_drained();
      write_settings(1'b0, 1'b0, 1023, 0);
      pending_requests.push_back(make_query(5, 5));
      pending_requests.push_back(make_load(2, 0, 64, 0, 64));
      wait_drained();

      // random phases over several settings
      write_settings(1'b1, 1'b1, 1023, 16);
      queue_random(130);
      wait_drained();
      write_settings(1'b0, 1'b1, 1023, 16);
      queue_random(130);
      wait_drained();
      write_settings(1'b1, 1'b1, 1, 31);
      quiet_phase = 1'b1;
      queue_random(120);
      wait_drained();
      quiet_phase = 1'b0;
      write_settings(1'b0, 1'b1, 0, 8);
      queue_random(110);
      wait_drained();
      write_settings(1'b1, 1'b1, 0, 3);
      queue_random(100);
      wait_drained();
      write_settings(1'b1, 1'b0, 512, 1);
      queue_random(80);
      wait_drained();
      write_settings(1'b0, 1'b1, 40, 16);
      queue_random(110);
      wait_drained();

      $display("tb: %0d loads and %0d queries, %0d of them blended", load_count,
               query_count, blend_count);
      $display("tb: modes, widths 0 to 1023 and scan counts 0 to 31 exercised");
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
